// ----- rtl/core/bdp_pkg.sv -----
// Shared types and constants for the branch direction predictor.
// No dependencies.
`default_nettype none

package bdp_pkg;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MIN         = 2'd0;
  localparam ctr_t CTR_WEAK_TAKEN  = 2'd2;
  localparam ctr_t CTR_MAX         = 2'd3;

  localparam logic [1:0] MODE_LOCAL  = 2'd0;
  localparam logic [1:0] MODE_GLOBAL = 2'd1;
  localparam logic [1:0] MODE_GSHARE = 2'd2;

  localparam logic KIND_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_READ  = 3'b100
  } state_e;

  function automatic ctr_t ctr_update(input ctr_t ctr, input logic taken);
    ctr_t res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) res = ctr - 2'd1;
    end
    return res;
  endfunction

  function automatic logic ctr_predict(input ctr_t ctr);
    return ctr >= CTR_WEAK_TAKEN;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/branch_direction_predictor_unit.sv -----
// Branch direction predictor: 2-bit counter table in one synchronous RAM,
// indexed by PC, global history, or their XOR. Depends on bdp_pkg.
// An accepted request is read from the RAM into rdata_q; in the read state the
// prediction is registered into pred_q and valid_o is strobed with predict_taken_o.
// busy stays high in that read state, in which the same entry is written back.
// Reset: a clearing pass writes weakly taken to every entry with busy high;
// config writes are taken during it. Receiver cannot stall.
`default_nettype none

module branch_direction_predictor_unit
  import bdp_pkg::*;
#(
  parameter int INDEX_BITS = 15
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind_i,
  input  wire logic [63:0] branch_address_i,
  input  wire logic        outcome_taken_i,
  // result
  output logic             valid_o,
  output logic             predict_taken_o,
  // config
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int Depth = 2 ** INDEX_BITS;

  typedef logic [INDEX_BITS-1:0] idx_t;

  state_e     state_q, state_d;
  idx_t       clr_cnt_q;
  idx_t       hist_q;
  logic [1:0] mode_q;
  idx_t       idx_q;
  logic       kind_q, taken_q;
  logic       valid_q, pred_q;

  ctr_t       mem [Depth];
  ctr_t       rdata_q;

  logic       accept;
  idx_t       pc_bits, rd_idx;
  logic       mem_we;
  idx_t       mem_waddr;
  ctr_t       mem_wdata;
  logic       cfg_we;
  logic       do_update;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign pc_bits = branch_address_i[INDEX_BITS+1:2];

  always_comb begin
    unique case (mode_q)
      MODE_GLOBAL: rd_idx = hist_q;
      MODE_GSHARE: rd_idx = pc_bits ^ hist_q;
      default:     rd_idx = pc_bits;  // local mode and the unused code
    endcase
  end

  assign do_update = (state_q == ST_READ) && (kind_q == KIND_UPDATE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = ctr_update(rdata_q, taken_q);
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = CTR_WEAK_TAKEN;
    end else if (do_update) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rdata_q <= mem[rd_idx];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_cnt_q == idx_t'(Depth - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (start) state_d = ST_READ;
      ST_READ:  state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      hist_q    <= '0;
      mode_q    <= MODE_LOCAL;
      valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == ST_READ);
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + idx_t'(1);
      end
      if (cfg_we) begin
        mode_q <= pwdata[1:0];
      end
      // history shifts after the update used the old value for its index
      if (do_update && (mode_q == MODE_GLOBAL || mode_q == MODE_GSHARE)) begin
        hist_q <= {hist_q[INDEX_BITS-2:0], taken_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q   <= rd_idx;
      kind_q  <= kind_i;
      taken_q <= outcome_taken_i;
    end
    if (state_q == ST_READ) begin
      pred_q <= ctr_predict(rdata_q);
    end
  end

  assign valid_o         = valid_q;
  assign predict_taken_o = pred_q;
  assign pready          = 1'b1;
  assign prdata          = (paddr[2] == 1'b0) ? {30'd0, mode_q} : 32'd0;

endmodule

`default_nettype wire

// ----- rtl/core/bdp_checker.sv -----
// Port-level checker for the branch direction predictor, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module bdp_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic valid_o,
  input wire logic pready
);

  logic accept;
  assign accept = start && !busy;

  // an accepted request blocks the next one during its read cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy low right after accepted request");

  // every accepted request yields its result strobe
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 valid_o)
    else $error("result strobe missing for accepted request");

  // a result only follows a busy cycle
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result strobe without a preceding request");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  // config port never inserts wait states
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind branch_direction_predictor_unit bdp_checker u_bdp_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o),
  .pready  (pready)
);

`default_nettype wire
